[rtl/assert_macros.svh]
// Assertion macros used by the RTL top level.
// Depends on nothing; included where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

[rtl/lfu_pkg.sv]
// Types and constants of the LFU cache table.
// No dependencies; used by every RTL module.
package lfu_pkg;
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int CAP_BITS   = 5;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic        cmd;
    logic signed [31:0] key;
    logic signed [31:0] data_in;
  } lfu_in_t;

  typedef struct packed {
    logic        hit;
    logic signed [31:0] data_out;
    logic        evicted;
    logic signed [31:0] evicted_key;
  } lfu_out_t;

  // Per-entry contents held in a cell.
  typedef struct packed {
    logic                  valid;
    logic [31:0]           key;
    logic [31:0]           value;
    logic [COUNT_BITS-1:0] cnt;
    logic [IDX_BITS-1:0]   rank;
  } lfu_entry_t;

  // Operation broadcast to all cells.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_TOUCH = 2'd1,
    OP_EVICT = 2'd2,
    OP_FILL  = 2'd3
  } lfu_op_t;

  typedef struct packed {
    lfu_op_t             op;
    logic [IDX_BITS-1:0] sel;
    logic [IDX_BITS-1:0] sel_rank;
    logic [31:0]         key;
    logic [31:0]         value;
    logic                wr_value;
  } lfu_ctl_t;
endpackage

[rtl/lfu_cell.sv]
// One cache entry cell of the LFU table; shifts its entry along the ring while scanning.
// Depends on lfu_pkg.
module lfu_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lfu_pkg::IDX_BITS-1:0] my_idx,
  input  logic                         rotate,
  input  lfu_pkg::lfu_entry_t          prev_ent,
  input  lfu_pkg::lfu_ctl_t            ctl,
  output lfu_pkg::lfu_entry_t          ent
);
  import lfu_pkg::*;

  lfu_entry_t ent_r, ent_nxt;
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (rotate) begin
      ent_nxt = prev_ent;
    end else begin
      case (ctl.op)
        OP_TOUCH: begin
          if (ctl.sel == my_idx) begin
            ent_nxt.rank = '0;
            if (ent_r.cnt != COUNT_MAX) ent_nxt.cnt = ent_r.cnt + 1'b1;
            if (ctl.wr_value) ent_nxt.value = ctl.value;
          end else if (ent_r.valid && ent_r.rank < ctl.sel_rank) begin
            ent_nxt.rank = ent_r.rank + 1'b1;
          end
        end
        OP_EVICT: begin
          if (ctl.sel == my_idx) ent_nxt.valid = 1'b0;
          else if (ent_r.valid && ent_r.rank > ctl.sel_rank)
            ent_nxt.rank = ent_r.rank - 1'b1;
        end
        OP_FILL: begin
          if (ctl.sel == my_idx) begin
            ent_nxt.valid = 1'b1;
            ent_nxt.key   = ctl.key;
            ent_nxt.value = ctl.value;
            ent_nxt.cnt   = {{(COUNT_BITS-1){1'b0}}, 1'b1};
            ent_nxt.rank  = '0;
          end else if (ent_r.valid) begin
            ent_nxt.rank = ent_r.rank + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      ent_r.key   <= ent_nxt.key;
      ent_r.value <= ent_nxt.value;
      ent_r.cnt   <= ent_nxt.cnt;
      ent_r.rank  <= ent_nxt.rank;
    end else begin
      ent_r <= ent_nxt;
    end
  end
endmodule

[rtl/lfu_cache_table_top.sv]
// Top level of the LFU cache table: cell ring, scan sequencer, result register.
// Depends on lfu_pkg, lfu_cell and assert_macros.svh.
//
//  channel | ports                        | handshake
//  input   | start, busy, in_data         | transfer when start && !busy
//  result  | out_valid, out_data          | one-cycle strobe, no stall
//  config  | cfg_we, cfg_capacity         | write when cfg_we
//
// Busy holds after the transfer while the ring of cells rotates once past a
// compare at cell 0, looking for the key and the victim; then an update state
// (touch, evict or fill) and a state that raises the strobe. An eviction adds
// a fill state. The strobe sits in the first idle cycle, so the next transfer
// can come as early as the strobe. The rotation sets the rate.
// Reset clears valid bits, entry count, capacity to 16 and the sequencer.
// The receiver cannot stall; busy is high from transfer until the strobe.
module lfu_cache_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  lfu_pkg::lfu_in_t                in_data,
  output logic                            out_valid,
  output lfu_pkg::lfu_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [lfu_pkg::CAP_BITS-1:0]    cfg_capacity
);
  import lfu_pkg::*;
`include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_UPDATE, S_FILL, S_DONE
  } state_t;

  state_t                state_r;
  logic [CAP_BITS-1:0]   capacity_r;
  logic [CAP_BITS-1:0]   count_r;
  logic [IDX_BITS:0]     step_r;
  lfu_in_t               req_r;
  // scan results
  logic                  found_r, vic_ok_r;
  logic [IDX_BITS-1:0]   hit_idx_r, hit_rank_r, vic_idx_r, vic_rank_r, free_idx_r;
  logic [COUNT_BITS-1:0] vic_cnt_r;
  logic [31:0]           hit_val_r, vic_key_r;
  logic                  free_ok_r;
  lfu_out_t              out_r;
  logic                  out_valid_r;

  lfu_entry_t ents [ENTRIES];
  lfu_ctl_t   ctl;
  logic       rotate;

  assign rotate = (state_r == S_SCAN);

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      lfu_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .my_idx   (IDX_BITS'(g)),
        .rotate   (rotate),
        .prev_ent (ents[(g + 1) % ENTRIES]),
        .ctl      (ctl),
        .ent      (ents[g])
      );
    end
  endgenerate

  // Cell 0 sees slot (step) during scan; after ENTRIES rotations the ring is home.
  logic [IDX_BITS-1:0] cur_idx;
  logic [CAP_BITS-1:0] cap_eff;
  logic                need_evict;
  assign cur_idx  = step_r[IDX_BITS-1:0];
  assign cap_eff  = (capacity_r > CAP_BITS'(ENTRIES)) ? CAP_BITS'(ENTRIES) : capacity_r;
  assign need_evict = (count_r >= cap_eff) && vic_ok_r;

  always_comb begin
    ctl          = '0;
    ctl.op       = OP_NONE;
    ctl.key      = req_r.key;
    ctl.value    = req_r.data_in;
    if (state_r == S_UPDATE) begin
      if (found_r && (!req_r.cmd || cap_eff != '0)) begin
        ctl.op       = OP_TOUCH;
        ctl.sel      = hit_idx_r;
        ctl.sel_rank = hit_rank_r;
        ctl.wr_value = req_r.cmd;
      end else if (!found_r && req_r.cmd && cap_eff != '0) begin
        if (need_evict) begin
          ctl.op       = OP_EVICT;
          ctl.sel      = vic_idx_r;
          ctl.sel_rank = vic_rank_r;
        end else if (free_ok_r) begin
          ctl.op  = OP_FILL;
          ctl.sel = free_idx_r;
        end
      end
    end else if (state_r == S_FILL) begin
      ctl.op  = OP_FILL;
      ctl.sel = free_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      capacity_r  <= CAP_BITS'(16);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) capacity_r <= cfg_capacity;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r     <= in_data;
            step_r    <= '0;
            found_r   <= 1'b0;
            vic_ok_r  <= 1'b0;
            free_ok_r <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // compare the entry now at cell 0
          if (ents[0].valid) begin
            if (ents[0].key == req_r.key) begin
              found_r    <= 1'b1;
              hit_idx_r  <= cur_idx;
              hit_rank_r <= ents[0].rank;
              hit_val_r  <= ents[0].value;
            end
            if (!vic_ok_r || ents[0].cnt < vic_cnt_r ||
                (ents[0].cnt == vic_cnt_r && ents[0].rank > vic_rank_r)) begin
              vic_ok_r   <= 1'b1;
              vic_idx_r  <= cur_idx;
              vic_cnt_r  <= ents[0].cnt;
              vic_rank_r <= ents[0].rank;
              vic_key_r  <= ents[0].key;
            end
          end else if (!free_ok_r) begin
            free_ok_r  <= 1'b1;
            free_idx_r <= cur_idx;
          end
          step_r <= step_r + 1'b1;
          if (step_r == (IDX_BITS+1)'(ENTRIES - 1)) state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          out_r.hit         <= found_r;
          out_r.data_out    <= (found_r && !req_r.cmd) ? hit_val_r : '0;
          out_r.evicted     <= 1'b0;
          out_r.evicted_key <= '0;
          state_r           <= S_DONE;
          if (ctl.op == OP_EVICT) begin
            out_r.evicted     <= 1'b1;
            out_r.evicted_key <= vic_key_r;
            // the victim's slot becomes free; fill the lower of it and the first free slot
            if (!free_ok_r || vic_idx_r < free_idx_r) free_idx_r <= vic_idx_r;
            count_r <= count_r - 1'b1;
            state_r <= S_FILL;
          end else if (ctl.op == OP_FILL) begin
            count_r <= count_r + 1'b1;
          end
        end
        S_FILL: begin
          count_r <= count_r + 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_NEXT(a_fill_after_evict, clk, rst_n, ctl.op == OP_EVICT, state_r == S_FILL)
  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CAP_BITS'(ENTRIES))
  `ASSERT_NEXT(a_strobe_one, clk, rst_n, out_valid, !out_valid)
endmodule
